/* sv/sst_pkg.sv */
// sst_pkg: request and result codes, datapath command and status types
// for the sorted set table; no dependencies

package sst_pkg;

  // request kinds (any other code behaves as a membership query)
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // commands from controller to datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_DECIDE,
    CMD_SHUP,
    CMD_PUT,
    CMD_SHDN,
    CMD_DROP,
    CMD_RESULT
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic up_done;
    logic dn_done;
    logic do_insert;
    logic do_delete;
  } dp_stat_t;

endpackage

/* sv/sst_datapath.sv */
// sst_datapath: entry memory, entry count, scan and shift pointers and the
// result registers of the sorted set table; depends on sst_pkg

module sst_datapath import sst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [1:0]         op,
  input  logic signed [31:0] value,
  output dp_stat_t           stat,
  output logic [1:0]         status,
  output logic               found,
  output logic [4:0]         entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // entry store
  logic signed [31:0] mem [CAPACITY];

  logic [1:0]         req_op;
  logic signed [31:0] req_value;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      rd_addr;
  logic               rd_pend;
  logic signed [31:0] rd_data;
  logic [CW-1:0]      pos;
  logic               hit;
  logic [1:0]         res_status;

  logic               stop_hit;
  logic               full;
  logic               rd_en;
  logic [CW-1:0]      rd_ptr;
  logic               wr_en;
  logic [CW-1:0]      wr_ptr;
  logic signed [31:0] wr_data;

  // scan stop, end of shift passes and branch decisions
  always_comb begin
    stop_hit       = rd_pend && (rd_data >= req_value);
    full           = (count >= CW'(CAPACITY));
    stat.scan_done = stop_hit || (!rd_pend && (idx >= count));
    stat.up_done   = !rd_pend && (idx <= pos);
    stat.dn_done   = !rd_pend && (idx >= count);
    stat.do_insert = (req_op == OP_INSERT) && !full && !hit;
    stat.do_delete = (req_op == OP_DELETE) && hit;
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_ptr  = idx;
    wr_en   = 1'b0;
    wr_ptr  = pos;
    wr_data = rd_data;
    case (cmd)
      CMD_SCAN: begin
        rd_en = !stop_hit && (idx < count);
      end
      CMD_SHUP: begin
        // read entry below, write it one place higher in the next cycle
        wr_en  = rd_pend;
        wr_ptr = rd_addr + CW'(1);
        rd_en  = (idx > pos);
        rd_ptr = idx - CW'(1);
      end
      CMD_SHDN: begin
        // read entry above, write it one place lower in the next cycle
        wr_en  = rd_pend;
        wr_ptr = rd_addr - CW'(1);
        rd_en  = (idx < count);
      end
      CMD_PUT: begin
        wr_en   = 1'b1;
        wr_data = req_value;
      end
      default: begin
      end
    endcase
  end

  // memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr[AW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD:   rd_pend <= 1'b0;
        CMD_SCAN:   rd_pend <= rd_en;
        CMD_SHUP:   rd_pend <= rd_en;
        CMD_SHDN:   rd_pend <= rd_en;
        CMD_DECIDE: rd_pend <= 1'b0;
        CMD_PUT:    count   <= count + CW'(1);
        CMD_DROP:   count   <= count - CW'(1);
        default: begin
        end
      endcase
    end
  end

  // request, pointer and result registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr <= rd_ptr;
    end
    case (cmd)
      CMD_LOAD: begin
        req_op    <= op;
        req_value <= value;
        idx       <= '0;
        hit       <= 1'b0;
        pos       <= count;
      end
      CMD_SCAN: begin
        if (stop_hit) begin
          hit <= (rd_data == req_value);
          pos <= rd_addr;
        end
        if (rd_en) begin
          idx <= idx + CW'(1);
        end
      end
      CMD_DECIDE: begin
        if (req_op == OP_INSERT) begin
          idx <= count;
          if (full) begin
            res_status <= ST_FULL;
          end else if (hit) begin
            res_status <= ST_DUP;
          end else begin
            res_status <= ST_DONE;
          end
        end else begin
          idx        <= pos + CW'(1);
          res_status <= hit ? ST_DONE : ST_MISSING;
        end
      end
      CMD_SHUP: begin
        if (rd_en) begin
          idx <= idx - CW'(1);
        end
      end
      CMD_SHDN: begin
        if (rd_en) begin
          idx <= idx + CW'(1);
        end
      end
      CMD_RESULT: begin
        status      <= res_status;
        found       <= hit;
        entry_count <= 5'(count);
      end
      default: begin
      end
    endcase
  end

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // never append to a full table
  a_put_not_full: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_PUT) |-> (count < CW'(CAPACITY)))
    else $error("insert into full table");

  // a removal always has an entry to remove
  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_DROP) |-> (count != '0))
    else $error("delete from empty table");

  // scan reads stay below the entry count
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_SCAN && rd_pend) |-> (rd_addr < count))
    else $error("scan read beyond stored entries");

endmodule

/* sv/sst_ctrl.sv */
// sst_ctrl: request sequencer of the sorted set table, drives datapath
// commands and the handshakes; depends on sst_pkg

module sst_ctrl import sst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHUP,
    S_PUT,
    S_SHDN,
    S_DROP,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // command and next state
  always_comb begin
    cmd        = CMD_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd = CMD_DECIDE;
        if (stat.do_insert) begin
          state_next = S_SHUP;
        end else if (stat.do_delete) begin
          state_next = S_SHDN;
        end else begin
          state_next = S_RESP;
        end
      end
      S_SHUP: begin
        cmd = CMD_SHUP;
        if (stat.up_done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd        = CMD_PUT;
        state_next = S_RESP;
      end
      S_SHDN: begin
        cmd = CMD_SHDN;
        if (stat.dn_done) begin
          state_next = S_DROP;
        end
      end
      S_DROP: begin
        cmd        = CMD_DROP;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd        = CMD_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == CMD_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a result load always raises valid
  a_result_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_RESULT) |=> out_valid)
    else $error("result loaded without valid");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> (cmd != CMD_RESULT))
    else $error("pending result overwritten");

endmodule

/* sv/sorted_set_table.sv */
// sorted_set_table: ascending set of signed 32-bit values, insert, delete, query
// steps: an accept step, a scan to the first entry not below the value, a decide
//   step, on insert or delete a shift of the entries above the insert or delete point
//   and a put or drop step, then a result step that waits while an earlier result is unread
// one request in flight; the entry memory moves one entry per cycle during a shift
// reset (rst, synchronous): empties the set; entry memory is not cleared

module sorted_set_table import sst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               found,
  output logic [4:0]         entry_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // request sequencer
  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // entry store and result registers
  sst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .value       (value),
    .stat        (stat),
    .status      (status),
    .found       (found),
    .entry_count (entry_count)
  );

endmodule

/* tb/sv/sorted_set_table_test.sv */
// sorted_set_table_test: self-checking testbench for the sorted set table
// drives insert, delete and membership requests, predicts each result from a shadow copy
// of the set or a pinned row, compares it field by field; depends on sst_pkg and sorted_set_table
`timescale 1ns / 100ps

module sorted_set_table_test import sst_pkg::*;;

  localparam int CAPACITY     = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 2 * CAPACITY + 30;
  localparam int RANDOM_ITEMS = 920;
  localparam int POOL_SIZE    = 20;
  localparam int PLAN_LEN     = 17;

  // request kinds not named in the package
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_OTHER = 2'd3;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] count;
  } set_result_t;

  // per request: a hand-written result, used instead of the shadow set when pinned
  typedef struct packed {
    logic        pinned;
    set_result_t want;
  } result_note_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] val;
    logic [4:0]         reps;
    logic signed [31:0] stride;
    logic               pinned;
    set_result_t        want;
  } plan_row_t;

  // directed requests; rows with several reps step the value by stride
  plan_row_t plan [PLAN_LEN] = '{
    '{OP_QUERY,  0,       1,   0, 1, '{ST_MISSING, 0, 0}},
    '{OP_DELETE, 5,       1,   0, 1, '{ST_MISSING, 0, 0}},
    '{OP_INSERT, 0,       1,   0, 1, '{ST_DONE,    0, 1}},
    '{OP_INSERT, VAL_MAX, 1,   0, 1, '{ST_DONE,    0, 2}},
    '{OP_INSERT, VAL_MIN, 1,   0, 1, '{ST_DONE,    0, 3}},
    '{OP_INSERT, 0,       1,   0, 1, '{ST_DUP,     1, 3}},
    '{OP_OTHER,  VAL_MAX, 1,   0, 1, '{ST_DONE,    1, 3}},
    '{OP_QUERY,  -1,      1,   0, 1, '{ST_MISSING, 0, 3}},
    '{OP_INSERT, -10,     13, -10, 0, '{ST_DONE,   0, 0}},
    '{OP_INSERT, 5,       1,   0, 1, '{ST_FULL,    0, 16}},
    '{OP_INSERT, 0,       1,   0, 1, '{ST_FULL,    1, 16}},
    '{OP_QUERY,  VAL_MIN, 1,   0, 1, '{ST_DONE,    1, 16}},
    '{OP_DELETE, VAL_MAX, 1,   0, 1, '{ST_DONE,    1, 15}},
    '{OP_DELETE, VAL_MIN, 1,   0, 1, '{ST_DONE,    1, 14}},
    '{OP_INSERT, VAL_MAX, 1,   0, 1, '{ST_DONE,    0, 15}},
    '{OP_DELETE, 0,       1,   0, 0, '{ST_DONE,    0, 0}},
    '{OP_DELETE, -70,     1,   0, 0, '{ST_DONE,    0, 0}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op = OP_INSERT;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic               found;
  logic [4:0]         entry_count;

  // shadow copy of the set, kept in ascending order
  logic signed [31:0] stored_values [CAPACITY];
  int                 stored_count = 0;

  set_result_t  expected_results [$];
  result_note_t request_notes [$];

  int  mismatches = 0;
  int  requests_taken = 0;
  int  results_checked = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  int  times_full = 0;
  int  times_emptied = 0;
  int  cycle_count = 0;
  bit  no_gaps = 1'b0;
  bit  hold_output = 1'b0;

  sorted_set_table #(.CAPACITY(CAPACITY)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .entry_count (entry_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // applies one request to the shadow set and returns the result it should give
  function automatic set_result_t apply_request(input logic [1:0] kind,
                                                input logic signed [31:0] v);
    set_result_t r;
    int          pos;
    int          k;
    logic        hit;
    pos = 0;
    while (pos < stored_count && stored_values[pos] < v) pos++;
    hit = (pos < stored_count) && (stored_values[pos] == v);
    r.found = hit;
    r.status = hit ? ST_DONE : ST_MISSING;
    case (kind)
      OP_INSERT: begin
        if (stored_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (hit) begin
          r.status = ST_DUP;
        end else begin
          for (k = stored_count; k > pos; k--) stored_values[k] = stored_values[k - 1];
          stored_values[pos] = v;
          stored_count++;
          r.status = ST_DONE;
          if (stored_count == CAPACITY) times_full++;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          for (k = pos; k + 1 < stored_count; k++) stored_values[k] = stored_values[k + 1];
          stored_count--;
          if (stored_count == 0) times_emptied++;
        end
      end
      default: ;
    endcase
    r.count = 5'(stored_count);
    return r;
  endfunction

  // present one request after a random gap and hold it until accepted
  task automatic send_request(input logic [1:0] kind, input logic signed [31:0] v,
                              input result_note_t note);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_notes.push_back(note);
    in_valid <= 1'b1;
    op <= kind;
    value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // result checking and prediction on accepted requests
  always @(posedge clk) begin : scoreboard
    set_result_t  got;
    set_result_t  want;
    set_result_t  model;
    result_note_t note;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{status, found, entry_count};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: status %0d found %0d count %0d",
                                    got.status, got.found, got.count));
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.found != want.found)
            report_mismatch($sformatf("found %0d, expected %0d", got.found, want.found));
          if (got.count != want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d", got.count, want.count));
          status_seen[want.status]++;
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        note = request_notes.pop_front();
        model = apply_request(op, value);
        expected_results.push_back(note.pinned ? note.want : model);
        requests_taken++;
      end
    end
  end

  // result side: random stalls, sometimes only once a result is waiting, plus long holds
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!out_valid);
        end
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int                 row;
    int                 rep;
    int                 sent;
    int                 phase;
    int                 pick;
    int                 idx;
    mix_t               mix;
    logic [1:0]         kind;
    logic signed [31:0] v;
    logic signed [31:0] value_pool [POOL_SIZE];

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (row = 0; row < PLAN_LEN; row++) begin
      for (rep = 0; rep < plan[row].reps; rep++) begin
        send_request(plan[row].kind, plan[row].val + rep * plan[row].stride,
                     '{plan[row].pinned, plan[row].want});
      end
    end

    // random phases that alternately fill, drain and churn the set
    for (idx = 0; idx < POOL_SIZE; idx++) value_pool[idx] = $urandom;
    hold_output = 1'b1;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mix = mix_t'(phase % 3);
      no_gaps = ($urandom_range(0, 4) == 0);
      if (phase == 9) hold_output = 1'b1;
      // refresh part of the value pool, half wide values and half near zero
      for (idx = 0; idx < 4; idx++) begin
        v = $urandom_range(0, 100);
        value_pool[$urandom_range(0, POOL_SIZE - 1)] =
          ($urandom_range(0, 1) == 1) ? $urandom : v - 50;
      end
      repeat ($urandom_range(30, 70)) begin
        pick = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  kind = (pick < 70) ? OP_INSERT : (pick < 80) ? OP_DELETE :
                            (pick < 95) ? OP_QUERY : OP_OTHER;
          MIX_DRAIN: kind = (pick < 15) ? OP_INSERT : (pick < 80) ? OP_DELETE :
                            (pick < 95) ? OP_QUERY : OP_OTHER;
          default:   kind = (pick < 40) ? OP_INSERT : (pick < 75) ? OP_DELETE :
                            (pick < 95) ? OP_QUERY : OP_OTHER;
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 16) begin
          v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 18) begin
          case ($urandom_range(0, 3))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX;
            2:       v = 0;
            default: v = -1;
          endcase
        end else begin
          v = $urandom;
        end
        send_request(kind, v, '0);
        sent++;
      end
      phase++;
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    // drain outstanding results, then watch for stray ones
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d requests, %0d results checked: done %0d, duplicate %0d, full %0d, missing %0d",
             requests_taken, results_checked, status_seen[ST_DONE], status_seen[ST_DUP],
             status_seen[ST_FULL], status_seen[ST_MISSING]);
    $display("set filled to capacity %0d times and emptied %0d times, %0d mismatches",
             times_full, times_emptied, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
